/* rtl/pic_pkg.sv */
// Package for the platform interrupt controller: register map, operation and
// status codes, and the request and response types passed between modules.
// No dependencies.
package pic_pkg;

    // Default number of interrupt sources.
    localparam int NUM_SOURCES_DEF = 32;

    // Field widths fixed by the channel definitions.
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 24;
    localparam int SIZE_W  = 2;
    localparam int DATA_W  = 32;
    localparam int LINES_W = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LINES = 2'd2;

    // Access size codes; only word accesses are legal.
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

    // Register word addresses.
    localparam logic [ADDR_W-1:0] ADDR_PENDING   = 24'h000400;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE    = 24'h000800;
    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 24'h080000;
    localparam logic [ADDR_W-1:0] ADDR_CLAIM     = 24'h080001;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAULT    = 2'd1,
        ST_MISALIGN = 2'd2
    } status_t;

    // One request as held in the input register.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  word_index;
        logic [SIZE_W-1:0]  access_size;
        logic [DATA_W-1:0]  write_data;
        logic [LINES_W-1:0] line_levels;
    } req_t;

    // One response as produced by the execute logic.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        status_t           status;
        logic              irq;
    } rsp_t;

endpackage

/* rtl/pic_claim.sv */
// Claim search for the platform interrupt controller: finds the lowest
// enabled pending source above 0. Depends on pic_pkg.
module pic_claim #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF,
    parameter int ID_W        = $clog2(NUM_SOURCES)
) (
    input  logic [NUM_SOURCES-1:0] pending,
    input  logic [NUM_SOURCES-1:0] enable,
    output logic [NUM_SOURCES-1:0] claim_onehot,
    output logic [ID_W-1:0]        claim_id
);
    import pic_pkg::*;

    // Source 0 never takes part in a claim.
    localparam logic [NUM_SOURCES-1:0] SRC_KEEP = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    logic [NUM_SOURCES-1:0] cand;

    // Isolate the lowest set candidate bit with the two's complement trick.
    always_comb begin
        cand         = pending & enable & SRC_KEEP;
        claim_onehot = cand & (~cand + NUM_SOURCES'(1));
    end

    // Encode the one-hot winner; all zero gives id 0.
    always_comb begin
        claim_id = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (claim_onehot[i]) begin
                claim_id = claim_id | ID_W'(i);
            end
        end
    end

endmodule

/* rtl/pic_core.sv */
// Execute stage of the platform interrupt controller: register decode, the
// source state registers and the line update that follows every request.
// Depends on pic_pkg and pic_claim.
module pic_core #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            exec_en,
    input  pic_pkg::req_t   req,
    output pic_pkg::rsp_t   rsp
);
    import pic_pkg::*;

    localparam int ID_W = $clog2(NUM_SOURCES);
    localparam logic [NUM_SOURCES-1:0] SRC_KEEP = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    logic [NUM_SOURCES-1:0] pending_reg,  pending_next;
    logic [NUM_SOURCES-1:0] enable_reg,   enable_next;
    logic [NUM_SOURCES-1:0] inserv_reg,   inserv_next;
    logic [NUM_SOURCES-1:0] lines_reg,    lines_next;

    logic [NUM_SOURCES-1:0] pend_acc;
    logic [NUM_SOURCES-1:0] inserv_acc;
    logic [NUM_SOURCES-1:0] claim_onehot;
    logic [ID_W-1:0]        claim_id;
    logic [NUM_SOURCES-1:0] comp_hit;
    logic [DATA_W-1:0]      rdata;
    status_t                status;
    logic                   is_prio;

    pic_claim #(
        .NUM_SOURCES (NUM_SOURCES),
        .ID_W        (ID_W)
    ) u_claim (
        .pending      (pending_reg),
        .enable       (enable_reg),
        .claim_onehot (claim_onehot),
        .claim_id     (claim_id)
    );

    // Priority registers occupy word addresses 1 up to the last source.
    assign is_prio = (req.word_index != '0) &&
                     (req.word_index < ADDR_W'(NUM_SOURCES));

    // Decode a completion id into a source mask; ids out of range match nothing.
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            comp_hit[i] = (req.write_data == DATA_W'(i));
        end
    end

    // Register access, then the level update that follows every request.
    always_comb begin
        rdata       = '0;
        status      = ST_OK;
        pend_acc    = pending_reg;
        inserv_acc  = inserv_reg;
        enable_next = enable_reg;
        lines_next  = lines_reg;

        unique case (req.op)
            OP_READ, OP_WRITE: begin
                if (req.access_size != SIZE_WORD) begin
                    status = ST_MISALIGN;
                end else if (req.op == OP_READ) begin
                    priority if (is_prio) begin
                        rdata = DATA_W'(1);
                    end else if (req.word_index == ADDR_PENDING) begin
                        rdata = DATA_W'(pending_reg);
                    end else if (req.word_index == ADDR_ENABLE) begin
                        rdata = DATA_W'(enable_reg);
                    end else if (req.word_index == ADDR_THRESHOLD) begin
                        rdata = '0;
                    end else if (req.word_index == ADDR_CLAIM) begin
                        rdata    = DATA_W'(claim_id);
                        pend_acc = pending_reg & ~claim_onehot;
                    end else begin
                        status = ST_FAULT;
                    end
                end else begin
                    priority if (is_prio) begin
                        status = ST_OK;
                    end else if (req.word_index == ADDR_ENABLE) begin
                        enable_next = req.write_data[NUM_SOURCES-1:0] & SRC_KEEP;
                    end else if (req.word_index == ADDR_THRESHOLD) begin
                        status = ST_OK;
                    end else if (req.word_index == ADDR_CLAIM) begin
                        inserv_acc = inserv_reg & ~(comp_hit & enable_reg);
                    end else begin
                        status = ST_FAULT;
                    end
                end
            end
            OP_LINES: begin
                lines_next = req.line_levels[NUM_SOURCES-1:0];
            end
            default: begin
                status = ST_OK;
            end
        endcase

        // Active lines not in service become pending and enter service.
        pending_next = pend_acc | (lines_next & ~inserv_acc);
        inserv_next  = inserv_acc | lines_next;

        rsp.read_data = rdata;
        rsp.status    = status;
        rsp.irq       = |(pending_next & enable_next);
    end

    // State registers advance once per executed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            enable_reg  <= '0;
            inserv_reg  <= '0;
            lines_reg   <= '0;
        end else if (exec_en) begin
            pending_reg <= pending_next;
            enable_reg  <= enable_next;
            inserv_reg  <= inserv_next;
            lines_reg   <= lines_next;
        end
    end

endmodule

/* rtl/platform_interrupt_controller.sv */
// Top level of the platform interrupt controller: input register, result
// register and handshake control around the execute stage.
// Depends on pic_pkg and pic_core.

// A simplified interrupt controller for up to 32 level-triggered sources with
// no priorities. Each request is a register read, a register write or an
// update of the source line levels, and gives exactly one response with read
// data, a status code and the interrupt output as it stands after the request.
// A request is captured in an input register and executed from there into a
// result register, which presents the response. The execute stage, including
// the claim search over all sources, is combinational, so one request per
// cycle is sustained as long as responses are taken; a stalled response holds
// one request in the input register before s_ready drops.
module platform_interrupt_controller #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pic_pkg::OP_W-1:0]     s_op,
    input  logic [pic_pkg::ADDR_W-1:0]   s_word_index,
    input  logic [pic_pkg::SIZE_W-1:0]   s_access_size,
    input  logic [pic_pkg::DATA_W-1:0]   s_write_data,
    input  logic [pic_pkg::LINES_W-1:0]  s_line_levels_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pic_pkg::DATA_W-1:0]   m_read_data,
    output logic [1:0]                   m_status,
    output logic                         m_irq_out
);
    import pic_pkg::*;

    logic  in_valid_reg;
    req_t  req_reg;
    logic  out_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  out_load;
    logic  exec_en;

    // The result register loads when empty or being emptied.
    assign out_load = !out_valid_reg || m_ready;
    assign exec_en  = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || exec_en;

    pic_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (exec_en),
        .req     (req_reg),
        .rsp     (rsp_next)
    );

    // Valid flags for the two stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.op          <= s_op;
            req_reg.word_index  <= s_word_index;
            req_reg.access_size <= s_access_size;
            req_reg.write_data  <= s_write_data;
            req_reg.line_levels <= s_line_levels_in;
        end
        if (exec_en) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = rsp_reg.read_data;
    assign m_status    = rsp_reg.status;
    assign m_irq_out   = rsp_reg.irq;

    // An error response never carries read data.
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_read_data == '0))
        else $error("error response with nonzero read data");

    // The unused status code is never produced.
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3))
        else $error("illegal status code");

    // An empty input register always takes a new request.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // A request held back by a stalled result stays in the input register.
    a_stall_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("stalled request lost");

endmodule
